[hdl/crxh_pkg.sv]
// Shared constants, the hash state type and helper functions for the string hash unit.
package crxh_pkg;

    localparam logic [31:0] INDEX_STEP  = 32'd314159;
    localparam logic [31:0] LENGTH_STEP = 32'd120343021;
    localparam logic [4:0]  ROT_STEP    = 5'd7;
    localparam logic [7:0]  UPPER_FIRST = 8'h41;
    localparam logic [7:0]  UPPER_LAST  = 8'h5A;
    localparam logic [7:0]  CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [31:0] accumulator;
        logic [31:0] index_term;
        logic [31:0] length_term;
        logic [4:0]  rotate_position;
    } hash_state_t;

    localparam hash_state_t STATE_RESET = '{
        accumulator:     32'd0,
        index_term:      INDEX_STEP,
        length_term:     LENGTH_STEP,
        rotate_position: 5'd0
    };

    // Rotate a 32-bit word left by a 5-bit amount.
    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {v, v} << n;
        return dbl[63:32];
    endfunction

    // Fold ASCII upper case letters to lower case; all other bytes pass unchanged.
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        if (b >= UPPER_FIRST && b <= UPPER_LAST)
        begin
            return b + CASE_OFFSET;
        end
        return b;
    endfunction

endpackage

[hdl/crxh_mix.sv]
// Per-word hash datapath: next state and finished hash from the current state.
module crxh_mix
    import crxh_pkg::*;
(
    input  hash_state_t cur,
    input  logic [7:0]  data_byte,
    input  logic        no_byte,
    input  logic        last_item,
    output hash_state_t nxt,
    output logic [31:0] hash_value
);

    logic [7:0]  folded;
    hash_state_t stepped;

    always_comb
    begin
        folded  = fold_case(data_byte);
        stepped = cur;
        if (!no_byte)
        begin
            stepped.accumulator = cur.accumulator
                                ^ rotl32({24'd0, folded}, cur.rotate_position)
                                ^ rotl32(cur.index_term, folded[4:0]);
            stepped.index_term      = cur.index_term + INDEX_STEP;
            stepped.length_term     = cur.length_term + LENGTH_STEP;
            stepped.rotate_position = cur.rotate_position + ROT_STEP;
        end
        hash_value = stepped.accumulator ^ stepped.length_term;
        // A finished name leaves the state ready for the next one.
        nxt = last_item ? STATE_RESET : stepped;
    end

endmodule

[hdl/case_folded_rotate_xor_string_hash_unit.sv]
// Top level of the case-folded rotate-XOR string hash unit.
//
// The unit hashes a name that arrives one byte per input word. Letters A-Z are
// folded to lower case, and each byte mixes two rotated terms into a 32-bit
// accumulator. A word with last_item set closes the name and produces one output
// word holding the hash; all other words produce nothing. A word with no_byte set
// steps no state, so a lone no_byte word with last_item set yields the hash of the
// empty name. The unit accepts one word every clock cycle for as long as the output
// side keeps up; a word is held in an input register, the hash arithmetic (two
// barrel rotates, XORs and constant adds) runs between that register and the
// output register, and out_valid rises once the last word of a name has passed
// from the input register through the arithmetic into the output register.
// The output register lets a new word enter while a finished hash still waits to be
// taken; only a last word facing a still-stalled output register holds the input.
module case_folded_rotate_xor_string_hash_unit
    import crxh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        no_byte,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    // Input register.
    logic        s0_valid_reg;
    logic [7:0]  s0_byte_reg;
    logic        s0_no_byte_reg;
    logic        s0_last_reg;

    // Running hash state and output register.
    hash_state_t state_reg;
    hash_state_t state_next;
    logic [31:0] hash_next;
    logic        out_valid_reg;
    logic [31:0] hash_reg;

    logic        out_free;
    logic        advance;
    logic        accept;

    crxh_mix u_mix (
        .cur        (state_reg),
        .data_byte  (s0_byte_reg),
        .no_byte    (s0_no_byte_reg),
        .last_item  (s0_last_reg),
        .nxt        (state_next),
        .hash_value (hash_next)
    );

    // The output register can take a new hash when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;
    // A word in the input register is processed unless it needs the output and
    // the output register is still occupied.
    assign advance  = s0_valid_reg && (!s0_last_reg || out_free);
    assign in_stall = s0_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (accept)
            begin
                s0_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s0_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg <= state_next;
            end

            if (advance && s0_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_byte_reg    <= data_byte;
            s0_no_byte_reg <= no_byte;
            s0_last_reg    <= last_item;
        end
        if (advance && s0_last_reg)
        begin
            hash_reg <= hash_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    // A closed name leaves the state at its start values.
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s0_last_reg) |=>
            (state_reg.accumulator == 32'd0 && state_reg.index_term == INDEX_STEP
             && state_reg.length_term == LENGTH_STEP && state_reg.rotate_position == 5'd0))
        else $error("hash state not cleared after last word");

    // A byteless word inside a name leaves the state untouched.
    a_no_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s0_no_byte_reg && !s0_last_reg) |=> $stable(state_reg))
        else $error("byteless word changed the hash state");

    // A new hash only appears after a last word was processed.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && s0_last_reg))
        else $error("output word without a closing input word");

    // The input is only held back when the input register is full.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s0_valid_reg && s0_last_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked last word");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the case-folded rotate-XOR string hash unit.
module tb_top
    import crxh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One row of the directed table. When known is set, the row closes a name
    // whose hash is obvious (the empty name), and that value is expected as typed.
    typedef struct packed {
        logic [7:0]  data;
        logic        skip;
        logic        close;
        logic        known;
        logic [31:0] hash;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 23;
    localparam int RANDOM_WORDS  = 1200;
    localparam int CALM_WORDS    = 150;
    localparam int PRESSURE_HOLD = 60;
    localparam int LONG_NAME_LEN = 200;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        no_byte;
    logic        last_item;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] hash_value;

    // Hashes still owed by the unit, oldest first.
    logic [31:0] pending_hashes[$];
    int          error_count = 0;

    // Shadow copy of the hash state, advanced on every accepted word.
    logic [31:0] shadow_acc;
    logic [31:0] shadow_index;
    logic [31:0] shadow_length;
    logic [4:0]  shadow_rot;

    // Handshake between the sender and the receiver's stall process.
    bit          calm_phase = 1'b0;
    bit          pressure_request = 1'b0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 1'b1, LENGTH_STEP},   // empty name straight after reset
        '{8'h00, 1'b0, 1'b0, 1'b0, 32'd0},         // a zero byte is still hashed
        '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h41, 1'b0, 1'b0, 1'b0, 32'd0},         // first upper case letter
        '{8'h5A, 1'b0, 1'b0, 1'b0, 32'd0},         // last upper case letter
        '{8'h40, 1'b0, 1'b0, 1'b0, 32'd0},         // just below the letters
        '{8'h5B, 1'b0, 1'b0, 1'b0, 32'd0},         // just above the letters
        '{8'h00, 1'b1, 1'b0, 1'b0, 32'd0},         // byteless word inside a name
        '{8'h80, 1'b0, 1'b1, 1'b0, 32'd0},         // non-ASCII byte closes the name
        '{8'h41, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h62, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h5A, 1'b0, 1'b1, 1'b0, 32'd0},
        '{8'h61, 1'b0, 1'b0, 1'b0, 32'd0},         // same name in other case
        '{8'h42, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h7A, 1'b0, 1'b1, 1'b0, 32'd0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hAA, 1'b1, 1'b1, 1'b0, 32'd0},         // byteless word closes a name
        '{8'hFF, 1'b1, 1'b1, 1'b1, LENGTH_STEP},   // empty name, ignored byte all ones
        '{8'h55, 1'b0, 1'b1, 1'b0, 32'd0},         // one-byte name
        '{8'h60, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h7B, 1'b0, 1'b1, 1'b0, 32'd0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 32'd0},         // stray byteless word between names
        '{8'h00, 1'b0, 1'b1, 1'b0, 32'd0}          // name made of one zero byte
    };

    case_folded_rotate_xor_string_hash_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .no_byte    (no_byte),
        .last_item  (last_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Give up long after the slowest legal run would have finished.
    initial
    begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

    // Rotate left; a zero amount leaves the word alone.
    function automatic logic [31:0] rotate_left(input logic [31:0] v, input logic [4:0] n);
        if (n == 5'd0)
        begin
            return v;
        end
        return (v << n) | (v >> (6'd32 - n));
    endfunction

    task automatic clear_shadow();
        shadow_acc    = 32'd0;
        shadow_index  = INDEX_STEP;
        shadow_length = LENGTH_STEP;
        shadow_rot    = 5'd0;
    endtask

    // Advance the shadow state by one accepted word. The hash is valid only
    // when the word closes a name, and the state then starts over.
    task automatic fold_word(input logic [7:0] data, input logic skip, input logic close,
                             output logic [31:0] hash);
        logic [7:0] folded;
        folded = data;
        if (folded >= UPPER_FIRST && folded <= UPPER_LAST)
        begin
            folded = folded + CASE_OFFSET;
        end
        if (!skip)
        begin
            shadow_acc    = shadow_acc ^ rotate_left({24'd0, folded}, shadow_rot);
            shadow_acc    = shadow_acc ^ rotate_left(shadow_index, folded[4:0]);
            shadow_index  = shadow_index + INDEX_STEP;
            shadow_length = shadow_length + LENGTH_STEP;
            shadow_rot    = shadow_rot + ROT_STEP;
        end
        hash = shadow_acc ^ shadow_length;
        if (close)
        begin
            clear_shadow();
        end
    endtask

    // Offer one word, wait for the unit to take it, then record what it owes.
    // A random idle burst may come first, except in the calm tail of the run.
    task automatic send_word(input logic [7:0] data, input logic skip, input logic close,
                             input logic known, input logic [31:0] typed_hash);
        logic [31:0] hash;
        if (!calm_phase && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= data;
        no_byte   <= skip;
        last_item <= close;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        fold_word(data, skip, close, hash);
        if (close)
        begin
            pending_hashes.push_back(known ? typed_hash : hash);
        end
    endtask

    // Random name byte, weighted toward letters so the case folding is busy.
    function automatic logic [7:0] random_name_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(32'h41, 32'h5A));
            4, 5, 6:    return 8'($urandom_range(32'h61, 32'h7A));
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Send one complete name of the given length. A name of length zero is the
    // empty name. Byteless words may appear inside, and about a third of the
    // names are closed by a byteless word instead of by their last byte.
    task automatic send_name(input int length, output int words);
        bit close_on_skip;
        words = 0;
        close_on_skip = (length == 0) || ($urandom_range(0, 2) == 0);
        for (int i = 0; i < length; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_word(8'($urandom), 1'b1, 1'b0, 1'b0, 32'd0);
            end
            send_word(random_name_byte(), 1'b0,
                      (i == length - 1) && !close_on_skip, 1'b0, 32'd0);
            words++;
        end
        if (close_on_skip)
        begin
            send_word(8'($urandom), 1'b1, 1'b1, 1'b0, 32'd0);
            words++;
        end
    endtask

    // Sender: reset, directed table, random names, then drain and report.
    initial
    begin
        int  sent;
        int  words;
        bit  long_done;
        in_valid  <= 1'b0;
        data_byte <= 8'd0;
        no_byte   <= 1'b0;
        last_item <= 1'b0;
        rst_n     <= 1'b0;
        clear_shadow();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i].data, directed_rows[i].skip, directed_rows[i].close,
                      directed_rows[i].known, directed_rows[i].hash);
        end

        // Ask the receiver for one long hold-off while names keep coming, so the
        // output register fills and the unit has to stall its input.
        pressure_request = 1'b1;
        sent = 0;
        long_done = 1'b0;
        while (sent < RANDOM_WORDS)
        begin
            calm_phase = (RANDOM_WORDS - sent) < CALM_WORDS;
            if (!long_done && sent >= RANDOM_WORDS / 2)
            begin
                // One long name wraps the length product and the rotate
                // position several times over.
                send_name(LONG_NAME_LEN, words);
                long_done = 1'b1;
                sent += words;
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    send_word(8'($urandom), 1'b1, 1'b0, 1'b0, 32'd0);
                end
                if ($urandom_range(0, 11) == 0)
                begin
                    send_name($urandom_range(30, 70), words);
                end
                else
                begin
                    send_name($urandom_range(0, 12), words);
                end
                sent += words;
            end
        end

        in_valid <= 1'b0;
        while (pending_hashes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_hashes.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Receiver stall: short random bursts, one long hold-off on request, and
    // none at all once the calm tail of the run begins.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_request)
            begin
                pressure_request = 1'b0;
                stall_left = PRESSURE_HOLD;
            end
            else if (stall_left == 0 && !calm_phase && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 8);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Every hash the unit hands over must match the oldest one owed.
    always @(posedge clk)
    begin
        logic [31:0] owed;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hashes.size() == 0)
            begin
                $display("%0t: hash expected none, actual %08h", $time, hash_value);
                error_count++;
            end
            else
            begin
                owed = pending_hashes.pop_front();
                if (hash_value !== owed)
                begin
                    $display("%0t: hash_value expected %08h, actual %08h",
                             $time, owed, hash_value);
                    error_count++;
                end
            end
        end
    end

endmodule

[filelist.f]
hdl/crxh_pkg.sv
hdl/crxh_mix.sv
hdl/case_folded_rotate_xor_string_hash_unit.sv
test/tb_top.sv
